// ===== design/indirect_jump_operand_decoder_assert.svh =====
// Assertion macros shared by the indirect jump operand decoder.
`ifndef INDIRECT_JUMP_OPERAND_DECODER_ASSERT_SVH
`define INDIRECT_JUMP_OPERAND_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under an active-low reset.
`define IJOD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ijod assertion failed");
// Next-cycle implication under an active-low reset.
`define IJOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ijod assertion failed");
`else
`define IJOD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IJOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ijod_pkg.sv =====
// Types, constants and helper functions of the indirect jump operand decoder.
package ijod_pkg;

  localparam int WinBytesMax    = 15;
  localparam int MaxPrefixesDef = 4;
  localparam int WinBytesDef    = 15;
  localparam int QueueDepthDef  = 2;
  // Bytes kept after the opcode: ModRM, SIB and four displacement bytes.
  localparam int ExtBytes       = 6;

  localparam logic [7:0] OpcJmpInd = 8'hFF;
  localparam logic [7:0] PfxCs     = 8'h2E;
  localparam logic [7:0] PfxEs     = 8'h26;
  localparam logic [7:0] PfxSs     = 8'h36;
  localparam logic [7:0] PfxDs     = 8'h3E;
  localparam logic [7:0] PfxFs     = 8'h64;
  localparam logic [7:0] PfxGs     = 8'h65;
  localparam logic [7:0] PfxOpSize = 8'h66;
  localparam logic [7:0] PfxAdSize = 8'h67;
  localparam logic [7:0] PfxLock   = 8'hF0;
  localparam logic [7:0] PfxRepne  = 8'hF2;
  localparam logic [7:0] PfxRep    = 8'hF3;

  localparam logic [2:0] RegJmpNear = 3'd4;
  localparam logic [2:0] RmSib      = 3'd4;
  localparam logic [2:0] RmDisp32   = 3'd5;
  localparam logic [2:0] IdxNone    = 3'd4;
  localparam logic [1:0] ModNoDisp  = 2'd0;
  localparam logic [1:0] ModDisp8   = 2'd1;
  localparam logic [1:0] ModDisp32  = 2'd2;
  localparam logic [1:0] ModReg     = 2'd3;

  typedef enum logic [2:0] {
    ST_NOT_FF4    = 3'd0,
    ST_RESOLVED   = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_ADDR_SIZE  = 3'd3,
    ST_SEGMENT    = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] bytes_low;
    logic [55:0] bytes_high;
    logic [3:0]  window_length;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic        reg_operand;
    logic [2:0]  target_reg;
    logic        base_present;
    logic [2:0]  base_reg;
    logic        index_present;
    logic [2:0]  index_reg;
    logic [3:0]  scale_factor;
    logic        disp_present;
    logic [31:0] displacement;
    logic [3:0]  instr_size;
    logic        cs_override;
  } out_rsp_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    status_e                   status;   // final unless ST_RESOLVED
    logic [3:0]                pos;      // opcode position
    logic [3:0]                avail;    // valid bytes after ModRM
    logic                      has_seg;  // a segment override was seen (CS if resolved)
    logic [ExtBytes-1:0][7:0]  ext;      // ModRM first
  } front_t;

  function automatic logic is_legacy_prefix(input logic [7:0] b);
    return b inside {PfxLock, PfxRepne, PfxRep, PfxCs, PfxSs, PfxDs, PfxEs,
                     PfxFs, PfxGs, PfxOpSize, PfxAdSize};
  endfunction

  function automatic logic is_seg_prefix(input logic [7:0] b);
    return b inside {PfxCs, PfxEs, PfxSs, PfxDs, PfxFs, PfxGs};
  endfunction

endpackage

// ===== design/indirect_jump_operand_decoder.sv =====
// Top level of the indirect near jump operand decoder.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------
//   in      | request   | in_valid_i / in_stall_o | in_req_i  (in_req_t)
//   out     | result    | out_valid_o/out_stall_i | out_rsp_o (out_rsp_t)
//
// A request passes the queue, then the output register: the front end
// classifies it in the accepting cycle and writes it into the queue, and the
// back end decodes it into the output register on the next edge it can.
// One request per cycle is sustained while the output is not stalled; the
// queue depth sets how many requests are absorbed during an output stall.
// Reset empties the queue and the output register; no clearing pass runs.
`include "indirect_jump_operand_decoder_assert.svh"

module indirect_jump_operand_decoder #(
  parameter int MaxPrefixes = ijod_pkg::MaxPrefixesDef,
  parameter int WindowBytes = ijod_pkg::WinBytesDef,
  parameter int QueueDepth  = ijod_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ijod_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ijod_pkg::out_rsp_t out_rsp_o
);

  ijod_pkg::front_t front_w;
  ijod_pkg::front_t q_data_w;
  logic             q_full_w;
  logic             q_valid_w;
  logic             q_pop_w;
  logic             in_accept_w;

  // The front end is purely combinational; its result goes straight into
  // the queue, so the input stalls only while the queue is full.
  assign in_stall_o  = q_full_w;
  assign in_accept_w = in_valid_i && !q_full_w;

  ijod_front #(
    .MaxPrefixes (MaxPrefixes),
    .WindowBytes (WindowBytes)
  ) u_front (
    .req_i   (in_req_i),
    .front_o (front_w)
  );

  ijod_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept_w),
    .push_data_i (front_w),
    .pop_i       (q_pop_w),
    .full_o      (q_full_w),
    .valid_o     (q_valid_w),
    .pop_data_o  (q_data_w)
  );

  // The back end pulls from the queue whenever its output register is free
  // or is being emptied in the same cycle.
  ijod_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid_w),
    .item_i       (q_data_w),
    .item_pop_o   (q_pop_w),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

  // Anything but a resolved status carries all-zero operand fields.
  `IJOD_ASSERT_IMPL(a_unresolved_zero, clk_i, rst_ni,
    out_valid_o && out_rsp_o.status != ijod_pkg::ST_RESOLVED,
    !out_rsp_o.reg_operand && out_rsp_o.target_reg == '0 &&
    !out_rsp_o.base_present && out_rsp_o.base_reg == '0 &&
    !out_rsp_o.index_present && out_rsp_o.index_reg == '0 &&
    out_rsp_o.scale_factor == '0 && !out_rsp_o.disp_present &&
    out_rsp_o.displacement == '0 && out_rsp_o.instr_size == '0 &&
    !out_rsp_o.cs_override)

  // A register target never carries memory operand fields.
  `IJOD_ASSERT_IMPL(a_reg_form_no_mem, clk_i, rst_ni,
    out_valid_o && out_rsp_o.reg_operand,
    !out_rsp_o.base_present && !out_rsp_o.index_present &&
    out_rsp_o.scale_factor == '0 && !out_rsp_o.disp_present)

  // The input only stalls while the queue holds requests.
  `IJOD_ASSERT_IMPL(a_stall_needs_queue, clk_i, rst_ni,
    in_stall_o,
    q_valid_w)

  // A request entering an idle block reaches the output through the queue and the output register without waiting.
  `IJOD_ASSERT_NEXT(a_idle_latency, clk_i, rst_ni,
    in_accept_w && !q_valid_w && !out_valid_o,
    ##1 out_valid_o)

endmodule

// ===== design/ijod_front.sv =====
// Front end: prefix scan, opcode and ModRM checks, operand byte alignment.
module ijod_front #(
  parameter int MaxPrefixes = ijod_pkg::MaxPrefixesDef,
  parameter int WindowBytes = ijod_pkg::WinBytesDef
) (
  input  ijod_pkg::in_req_t  req_i,
  output ijod_pkg::front_t   front_o
);

  logic [7:0] win_w [ijod_pkg::WinBytesMax];
  logic [ijod_pkg::WinBytesMax-1:0] pre_w;
  logic [3:0] len_w;
  logic [3:0] pos_w;
  logic       has_seg_w;
  logic       seg_cs_w;
  logic       addr67_w;
  logic [7:0] opc_w;
  logic [ijod_pkg::ExtBytes-1:0][7:0] ext_w;
  logic [4:0] pos1_w;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      win_w[i] = req_i.bytes_low[8*i +: 8];
    end
    for (int i = 8; i < ijod_pkg::WinBytesMax; i++) begin
      win_w[i] = req_i.bytes_high[8*(i-8) +: 8];
    end
  end

  assign len_w = (req_i.window_length > 4'(WindowBytes)) ? 4'(WindowBytes)
                                                         : req_i.window_length;

  always_comb begin
    for (int i = 0; i < ijod_pkg::WinBytesMax; i++) begin
      pre_w[i] = ijod_pkg::is_legacy_prefix(win_w[i]) && (4'(i) < len_w);
    end
  end

  // Opcode sits at the first non-prefix byte, or after the prefix limit.
  always_comb begin
    pos_w = 4'(MaxPrefixes);
    for (int i = MaxPrefixes - 1; i >= 0; i--) begin
      if (!pre_w[i]) begin
        pos_w = 4'(i);
      end
    end
  end

  // The last segment override wins.
  always_comb begin
    has_seg_w = 1'b0;
    seg_cs_w  = 1'b0;
    addr67_w  = 1'b0;
    for (int i = 0; i < MaxPrefixes; i++) begin
      if (4'(i) < pos_w) begin
        if (ijod_pkg::is_seg_prefix(win_w[i])) begin
          has_seg_w = 1'b1;
          seg_cs_w  = (win_w[i] == ijod_pkg::PfxCs);
        end
        if (win_w[i] == ijod_pkg::PfxAdSize) begin
          addr67_w = 1'b1;
        end
      end
    end
  end

  assign pos1_w = {1'b0, pos_w} + 5'd1;
  assign opc_w  = win_w[pos_w];

  always_comb begin
    logic [4:0] idx;
    for (int k = 0; k < ijod_pkg::ExtBytes; k++) begin
      idx = pos1_w + 5'(k);
      ext_w[k] = (idx < 5'(ijod_pkg::WinBytesMax)) ? win_w[idx[3:0]] : 8'h00;
    end
  end

  always_comb begin
    if (pos_w >= len_w || opc_w != ijod_pkg::OpcJmpInd) begin
      front_o.status = ijod_pkg::ST_NOT_FF4;
    end else if (pos1_w >= {1'b0, len_w}) begin
      front_o.status = ijod_pkg::ST_TRUNCATED;
    end else if (ext_w[0][5:3] != ijod_pkg::RegJmpNear) begin
      front_o.status = ijod_pkg::ST_NOT_FF4;
    end else if (addr67_w) begin
      front_o.status = ijod_pkg::ST_ADDR_SIZE;
    end else if (has_seg_w && !seg_cs_w) begin
      front_o.status = ijod_pkg::ST_SEGMENT;
    end else begin
      front_o.status = ijod_pkg::ST_RESOLVED;
    end
    front_o.pos     = pos_w;
    front_o.avail   = len_w - pos_w - 4'd2;
    front_o.has_seg = has_seg_w;
    front_o.ext     = ext_w;
  end

endmodule

// ===== design/ijod_queue.sv =====
// Short request queue between the front end and the back end.
module ijod_queue #(
  parameter int Depth = ijod_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ijod_pkg::front_t  push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output ijod_pkg::front_t  pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ijod_pkg::front_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/ijod_back.sv =====
// Back end: ModRM, SIB and displacement decode into the output register.
module ijod_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ijod_pkg::front_t   item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ijod_pkg::out_rsp_t out_rsp_o
);

  logic               out_valid_q, out_valid_d;
  ijod_pkg::out_rsp_t rsp_q, rsp_w;

  logic [1:0] mod_w;
  logic [2:0] rm_w;
  logic [7:0] sib_w;
  logic       has_sib_w;
  logic       mem_w;
  logic       base_p_w;
  logic       absolute_w;
  logic [2:0] dlen_w;
  logic [3:0] need_w;
  logic [31:0] disp_w;
  logic [3:0] size_w;

  assign mod_w     = item_i.ext[0][7:6];
  assign rm_w      = item_i.ext[0][2:0];
  assign sib_w     = item_i.ext[1];
  assign mem_w     = (mod_w != ijod_pkg::ModReg);
  assign has_sib_w = mem_w && (rm_w == ijod_pkg::RmSib);

  always_comb begin
    if (has_sib_w) begin
      base_p_w = !(mod_w == ijod_pkg::ModNoDisp && sib_w[2:0] == ijod_pkg::RmDisp32);
    end else begin
      base_p_w = !(mod_w == ijod_pkg::ModNoDisp && rm_w == ijod_pkg::RmDisp32);
    end
    absolute_w = (mod_w == ijod_pkg::ModNoDisp) &&
                 (rm_w == ijod_pkg::RmDisp32 || (has_sib_w && !base_p_w));
    if (mod_w == ijod_pkg::ModDisp8) begin
      dlen_w = 3'd1;
    end else if (mod_w == ijod_pkg::ModDisp32 || absolute_w) begin
      dlen_w = 3'd4;
    end else begin
      dlen_w = 3'd0;
    end
    need_w = {3'b000, has_sib_w} + {1'b0, dlen_w};
    if (has_sib_w) begin
      disp_w = (dlen_w == 3'd1) ? {{24{item_i.ext[2][7]}}, item_i.ext[2]}
                                : {item_i.ext[5], item_i.ext[4], item_i.ext[3],
                                   item_i.ext[2]};
    end else begin
      disp_w = (dlen_w == 3'd1) ? {{24{item_i.ext[1][7]}}, item_i.ext[1]}
                                : {item_i.ext[4], item_i.ext[3], item_i.ext[2],
                                   item_i.ext[1]};
    end
    size_w = item_i.pos + 4'd2 + need_w;
  end

  always_comb begin
    rsp_w = '0;
    if (item_i.status != ijod_pkg::ST_RESOLVED) begin
      rsp_w.status = item_i.status;
    end else if (need_w > item_i.avail) begin
      rsp_w.status = ijod_pkg::ST_TRUNCATED;
    end else begin
      rsp_w.status        = ijod_pkg::ST_RESOLVED;
      rsp_w.reg_operand   = !mem_w;
      rsp_w.target_reg    = rm_w;
      rsp_w.instr_size    = size_w;
      rsp_w.cs_override   = item_i.has_seg;
      if (mem_w) begin
        rsp_w.base_present = base_p_w;
        rsp_w.base_reg     = has_sib_w ? sib_w[2:0] : rm_w;
        if (has_sib_w) begin
          rsp_w.index_reg     = sib_w[5:3];
          rsp_w.index_present = (sib_w[5:3] != ijod_pkg::IdxNone);
          rsp_w.scale_factor  = 4'd1 << sib_w[7:6];
        end
        if (dlen_w != 3'd0) begin
          rsp_w.disp_present = 1'b1;
          rsp_w.displacement = disp_w;
        end
      end
    end
  end

  assign item_pop_o  = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = item_pop_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      rsp_q <= rsp_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== sim/indirect_jump_operand_decoder_checker.sv =====
// Checker for the indirect jump operand decoder: predicts each decode and compares results.
module indirect_jump_operand_decoder_checker
  import ijod_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_req_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_rsp_t    out_rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  out_rsp_t    expected_jumps[$];
  int unsigned mismatches;

  // Decodes one window the way the block should: prefixes, opcode, ModRM, SIB,
  // displacement, in the order in which each check can end the decode.
  function automatic out_rsp_t decode_jump(input in_req_t req);
    logic [14:0][7:0] win;
    out_rsp_t         res;
    out_rsp_t         trunc;
    int unsigned      len;
    int unsigned      pos;
    int unsigned      npref;
    int unsigned      cur;
    logic             seg_seen;
    logic             adsize_seen;
    logic             done;
    logic             absolute;
    logic [7:0]       seg_byte;
    logic [7:0]       modrm;
    logic [7:0]       sib;
    logic [1:0]       md;
    logic [2:0]       rm;
    win          = {req.bytes_high, req.bytes_low};
    res          = '0;
    res.status   = ST_NOT_FF4;
    trunc        = '0;
    trunc.status = ST_TRUNCATED;
    len          = req.window_length;
    if (len > WinBytesDef) len = WinBytesDef;
    pos         = 0;
    npref       = 0;
    seg_seen    = 1'b0;
    adsize_seen = 1'b0;
    seg_byte    = '0;
    done        = 1'b0;
    while (!done && pos < len && npref < MaxPrefixesDef) begin
      case (win[pos])
        PfxCs, PfxEs, PfxSs, PfxDs, PfxFs, PfxGs: begin
          seg_seen = 1'b1;
          seg_byte = win[pos];
        end
        PfxAdSize: adsize_seen = 1'b1;
        PfxLock, PfxRepne, PfxRep, PfxOpSize: ;
        default: done = 1'b1;
      endcase
      if (!done) begin
        npref++;
        pos++;
      end
    end
    if (pos >= len || win[pos] != OpcJmpInd) return res;
    if (pos + 1 >= len) return trunc;
    modrm = win[pos + 1];
    if (modrm[5:3] != RegJmpNear) return res;
    if (adsize_seen) begin
      res.status = ST_ADDR_SIZE;
      return res;
    end
    if (seg_seen && seg_byte != PfxCs) begin
      res.status = ST_SEGMENT;
      return res;
    end
    md  = modrm[7:6];
    rm  = modrm[2:0];
    cur = pos + 2;
    if (md != ModReg) begin
      if (rm == RmSib) begin
        if (cur >= len) return trunc;
        sib = win[cur];
        cur++;
        res.index_reg     = sib[5:3];
        res.index_present = (sib[5:3] != IdxNone);
        res.scale_factor  = 4'd1 << sib[7:6];
        res.base_reg      = sib[2:0];
        res.base_present  = !(md == ModNoDisp && sib[2:0] == RmDisp32);
      end else begin
        res.base_reg     = rm;
        res.base_present = !(md == ModNoDisp && rm == RmDisp32);
      end
      // With mod 0, rm 5 or a SIB without base means a bare 32-bit address.
      absolute = (md == ModNoDisp) &&
                 (rm == RmDisp32 || (rm == RmSib && !res.base_present));
      if (md == ModDisp8) begin
        if (cur >= len) return trunc;
        res.displacement = {{24{win[cur][7]}}, win[cur]};
        res.disp_present = 1'b1;
        cur++;
      end else if (md == ModDisp32 || absolute) begin
        if (len - cur < 4) return trunc;
        res.displacement = {win[cur + 3], win[cur + 2], win[cur + 1], win[cur]};
        res.disp_present = 1'b1;
        cur += 4;
      end
    end
    res.status        = ST_RESOLVED;
    res.reg_operand   = (md == ModReg);
    res.target_reg    = rm;
    res.instr_size    = cur[3:0];
    res.cs_override   = seg_seen;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      expected_jumps.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // A result cannot leave in the cycle its request enters, so compare first.
      if (out_valid_i && !out_stall_i) begin
        if (expected_jumps.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_jumps.pop_front();
          check_field("status", want.status, out_rsp_i.status);
          check_field("reg_operand", want.reg_operand, out_rsp_i.reg_operand);
          check_field("target_reg", want.target_reg, out_rsp_i.target_reg);
          check_field("base_present", want.base_present, out_rsp_i.base_present);
          check_field("base_reg", want.base_reg, out_rsp_i.base_reg);
          check_field("index_present", want.index_present, out_rsp_i.index_present);
          check_field("index_reg", want.index_reg, out_rsp_i.index_reg);
          check_field("scale_factor", want.scale_factor, out_rsp_i.scale_factor);
          check_field("disp_present", want.disp_present, out_rsp_i.disp_present);
          check_field("displacement", want.displacement, out_rsp_i.displacement);
          check_field("instr_size", want.instr_size, out_rsp_i.instr_size);
          check_field("cs_override", want.cs_override, out_rsp_i.cs_override);
        end
      end
      if (in_valid_i && !in_stall_i) expected_jumps.push_back(decode_jump(in_req_i));
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_jumps.size();
    end
  end

endmodule

// ===== sim/tb_indirect_jump_operand_decoder.sv =====
// Testbench top for the indirect jump operand decoder: stimulus, stalls and verdict.
module tb_indirect_jump_operand_decoder;
  import ijod_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_rsp_t    out_rsp;
  int unsigned mismatch_count;
  int unsigned pending_count;

  // While this is set, neither the request side nor the result side idles.
  logic        no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indirect_jump_operand_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  indirect_jump_operand_decoder_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // The result side stalls in about a fifth of the cycles, picked afresh at
  // every edge, so stalls land on every phase of the two-stage pipeline.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 21);
  end

  // Offers one request and returns at the edge where it is accepted. Idle
  // cycles go in front of the request; valid is dropped only for them, so a
  // back-to-back request keeps valid high across the edge.
  task automatic send_req(input in_req_t req);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the first n bytes of seq (first byte leftmost) as the window start,
  // with random filler above them and the given valid length.
  task automatic send_seq(input logic [119:0] seq, input int n, input int len);
    logic [14:0][7:0] win;
    in_req_t          req;
    for (int i = 0; i < 15; i++) begin
      win[i] = (i < n) ? seq[8*(n-1-i) +: 8] : 8'($urandom);
    end
    {req.bytes_high, req.bytes_low} = win;
    req.window_length = 4'(len);
    send_req(req);
  endtask

  initial begin
    logic [14:0][7:0] win;
    in_req_t          req;
    int               npfx;
    int               min_len;
    int               len;
    int               waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty window is not a jump even if it starts with FF.
    send_seq(120'hFFE0, 2, 0);
    // All-ones and all-zero windows of full length.
    send_seq({15{8'hFF}}, 15, 15);
    send_seq(120'h0, 15, 15);
    // Register forms, a near call (reg field 2) and a lone opcode byte.
    send_seq(120'hFFE0, 2, 2);
    send_seq(120'hFFE5, 2, 2);
    send_seq(120'hFF14, 2, 2);
    send_seq(120'hFF, 1, 1);
    // Absolute 32-bit address, complete and one byte short.
    send_seq(120'hFF25_78563412, 6, 6);
    send_seq(120'hFF25_78563412, 6, 5);
    // SIB with base ESP and no index, then SIB without base (absolute).
    send_seq(120'hFF24_24, 3, 3);
    send_seq(120'hFF24_8D_EFBEADDE, 7, 7);
    // 8-bit displacements at both sign extremes, and one missing.
    send_seq(120'hFF64_24_80, 4, 4);
    send_seq(120'hFF60_7F, 3, 3);
    send_seq(120'hFF64_24, 3, 3);
    // SIB byte missing, a 32-bit displacement cut short after SIB, and a complete one without SIB.
    send_seq(120'hFF24, 2, 2);
    send_seq(120'hFFA4_24_11, 4, 4);
    send_seq(120'hFFA0_FFFFFFFF, 6, 6);
    // Address-size prefix, a non-CS segment, CS alone, and the last override
    // winning in both orders. Address size is reported ahead of the segment.
    send_seq(120'h67FF20, 3, 3);
    send_seq(120'h64FF20, 3, 3);
    send_seq(120'h2EFF20, 3, 3);
    send_seq(120'h3E2EFF20, 4, 4);
    send_seq(120'h2E3EFF20, 4, 4);
    send_seq(120'h2667FF20, 4, 4);
    // Exactly the prefix limit, one over it, a SIB jump with CS at the limit, and a window of prefixes only.
    send_seq(120'hF0F2F366FF20, 6, 6);
    send_seq(120'h6666666666FF20, 7, 7);
    send_seq(120'h2E66F3F2FFA4CC78563412, 11, 15);
    send_seq(120'h2E2E2E, 3, 3);

    // Random part. Three in four windows are built as a jump with random
    // ModRM, SIB and displacement bytes behind a short prefix run; the rest
    // are noise. A stretch in the middle runs without any idling.
    for (int k = 0; k < 500; k++) begin
      no_idle = (k >= 150 && k < 300);
      for (int i = 0; i < 15; i++) win[i] = 8'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        npfx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
        for (int i = 0; i < npfx; i++) begin
          case ($urandom_range(0, 19))
            0:        win[i] = PfxLock;
            1:        win[i] = PfxRepne;
            2:        win[i] = PfxRep;
            3:        win[i] = PfxAdSize;
            4:        win[i] = PfxEs;
            5:        win[i] = PfxSs;
            6:        win[i] = PfxDs;
            7:        win[i] = PfxFs;
            8:        win[i] = PfxGs;
            9, 10:    win[i] = PfxOpSize;
            default:  win[i] = PfxCs;
          endcase
        end
        if ($urandom_range(0, 19) != 0) win[npfx] = OpcJmpInd;
        if ($urandom_range(0, 9) != 0) win[npfx + 1][5:3] = RegJmpNear;
        // Mostly long enough for the opcode and ModRM; the decoder's own
        // length then decides whether SIB or displacement bytes fall short.
        min_len = npfx + 2;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                          : min_len + $urandom_range(0, 15 - min_len);
      end else begin
        if ($urandom_range(0, 1) == 0) win[0] = OpcJmpInd;
        len = $urandom_range(0, 15);
      end
      {req.bytes_high, req.bytes_low} = win;
      req.window_length = 4'(len);
      send_req(req);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain: wait for every outstanding result, bounded, then a few more
    // cycles so a stray extra result would still be caught.
    waited = 0;
    while (pending_count != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[indirect_jump_operand_decoder] OK");
    end else begin
      $display("[indirect_jump_operand_decoder] ERROR");
    end
    $finish;
  end

  // Run guard, far beyond the slowest legal run of 527 requests.
  initial begin
    #2000000;
    $display("[indirect_jump_operand_decoder] ERROR");
    $finish;
  end

endmodule

// ===== indirect_jump_operand_decoder.f =====
+incdir+design
design/ijod_pkg.sv
design/ijod_front.sv
design/ijod_queue.sv
design/ijod_back.sv
design/indirect_jump_operand_decoder.sv
sim/indirect_jump_operand_decoder_checker.sv
sim/tb_indirect_jump_operand_decoder.sv
